// ----- sv/softplus_blend_two_lines_defines.svh -----
// ----------------------------------------------------------------------------
// Softplus blend assertion macros
// Shared concurrent assertion forms used by the softplus blend modules.
// ----------------------------------------------------------------------------
`ifndef SOFTPLUS_BLEND_TWO_LINES_DEFINES_SVH
`define SOFTPLUS_BLEND_TWO_LINES_DEFINES_SVH

// The property must hold in the same cycle as its trigger.
`define SBTL_ASSERT_NOW(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
      else $error("softplus blend check failed");

// The property must hold in the cycle after its trigger.
`define SBTL_ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("softplus blend check failed");

`endif

// ----- sv/sbtl_pkg.sv -----
// ----------------------------------------------------------------------------
// Softplus blend package
// Widths, codes, payload types and the softplus table of the blend block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbtl_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int SAMPLE_W   = 32;
   localparam int SHAPE_W    = 24;
   localparam int SHAPE_FRAC = 16;
   localparam int WIDTH_W    = 31;

   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int F_W    = PROD_W - FRAC_BITS + 1;
   localparam int D_W    = F_W + 1;
   localparam int H7_W   = WIDTH_W + 3;
   localparam int DMAG_W = WIDTH_W + 3;
   localparam int N_W    = DMAG_W + FRAC_BITS;
   localparam int Q_W    = FRAC_BITS + 3;
   localparam int T_W    = Q_W + 1;
   localparam int TAB_W  = FRAC_BITS + 3;
   localparam int SP_W   = FRAC_BITS + 3;
   localparam int HP_W   = WIDTH_W + SP_W;
   localparam int R_W    = D_W + 2;

   localparam int TABLE_LEN  = 15;
   localparam int IDX_W      = $clog2(TABLE_LEN);
   localparam int IDX_OFFSET = TABLE_LEN / 2;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [SHAPE_W-1:0] SHAPE_TWO = SHAPE_W'(2) << SHAPE_FRAC;

   typedef enum logic [1:0] {
      SHAPE_BELOW,
      SHAPE_ABOVE,
      SHAPE_EQUAL
   } shape_type;

   typedef enum logic [1:0] {
      KIND_UPPER,
      KIND_LOWER,
      KIND_INTERP
   } kind_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                       sample_not_finite;
      logic [SHAPE_W-1:0]         shape_value;
      logic signed [SAMPLE_W-1:0] slope_one;
      logic signed [SAMPLE_W-1:0] slope_two;
      logic signed [SAMPLE_W-1:0] offset_one;
      logic signed [SAMPLE_W-1:0] offset_two;
      logic [WIDTH_W-1:0]         smoothing_width;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] result_value;
      logic                        minus_infinity;
      logic                        saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic                    nf;
      shape_type               shape;
      kind_type                kind;
      logic                    neg;
      logic signed [F_W-1:0]   f1;
      logic signed [F_W-1:0]   f2;
      logic signed [D_W-1:0]   d;
      logic [WIDTH_W-1:0]      h;
      logic [DMAG_W-1:0]       dmag;
   } queue_item_type;

   function automatic logic [TAB_W-1:0] sp_q(input longint unsigned m);
      longint unsigned v;
      v = ((m << FRAC_BITS) + 64'd500000) / 64'd1000000;
      return TAB_W'(v);
   endfunction

   // log(1 + e^k) for k = -7 .. 7 in the fraction format of the datapath.
   localparam logic [TAB_W-1:0] SP_TABLE [TABLE_LEN] = '{
      sp_q(64'd911),     sp_q(64'd2476),    sp_q(64'd6715),    sp_q(64'd18150),
      sp_q(64'd48587),   sp_q(64'd126928),  sp_q(64'd313262),  sp_q(64'd693147),
      sp_q(64'd1313262), sp_q(64'd2126928), sp_q(64'd3048587), sp_q(64'd4018150),
      sp_q(64'd5006715), sp_q(64'd6002476), sp_q(64'd7000911)
   };

endpackage

// ----- sv/sbtl_chan_if.sv -----
// ----------------------------------------------------------------------------
// Softplus blend channel
// Valid and ready handshake carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sbtl_chan_if #(parameter type payload_type = logic) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ----- sv/sbtl_front.sv -----
// ----------------------------------------------------------------------------
// Softplus blend front end
// Forms both lines and their difference and classifies each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbtl_front import sbtl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  req_payload_type req_payload,
   output logic            req_ready,
   output logic            push_valid,
   output queue_item_type  push_item,
   input  logic            push_ready
);

   logic adv;

   logic                      s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0]  s1_prod1_ff, s1_prod1_in;
   logic signed [PROD_W-1:0]  s1_prod2_ff, s1_prod2_in;
   logic signed [SAMPLE_W-1:0] s1_b1_ff, s1_b1_in;
   logic signed [SAMPLE_W-1:0] s1_b2_ff, s1_b2_in;
   logic [WIDTH_W-1:0]        s1_h_ff, s1_h_in;
   logic                      s1_nf_ff, s1_nf_in;
   shape_type                 s1_shape_ff, s1_shape_in;

   logic                      s2_valid_ff, s2_valid_in;
   logic signed [F_W-1:0]     s2_f1_ff, s2_f1_in;
   logic signed [F_W-1:0]     s2_f2_ff, s2_f2_in;
   logic [WIDTH_W-1:0]        s2_h_ff, s2_h_in;
   logic [H7_W-1:0]           s2_h7_ff, s2_h7_in;
   logic                      s2_nf_ff, s2_nf_in;
   shape_type                 s2_shape_ff, s2_shape_in;

   logic                      s3_valid_ff, s3_valid_in;
   logic signed [F_W-1:0]     s3_f1_ff, s3_f1_in;
   logic signed [F_W-1:0]     s3_f2_ff, s3_f2_in;
   logic signed [D_W-1:0]     s3_d_ff, s3_d_in;
   logic [WIDTH_W-1:0]        s3_h_ff, s3_h_in;
   logic [H7_W-1:0]           s3_h7_ff, s3_h7_in;
   logic                      s3_nf_ff, s3_nf_in;
   shape_type                 s3_shape_ff, s3_shape_in;

   logic signed [D_W-1:0]     h7_s;
   logic signed [D_W-1:0]     d_abs;
   logic                      upper;
   logic                      lower;
   kind_type                  kind;

   assign adv       = !s3_valid_ff || push_ready;
   assign req_ready = adv && !reset;

   assign s1_valid_in = req_valid;
   assign s1_prod1_in = PROD_W'($signed(req_payload.slope_one))
                      * PROD_W'($signed(req_payload.sample_value));
   assign s1_prod2_in = PROD_W'($signed(req_payload.slope_two))
                      * PROD_W'($signed(req_payload.sample_value));
   assign s1_b1_in    = req_payload.offset_one;
   assign s1_b2_in    = req_payload.offset_two;
   assign s1_h_in     = req_payload.smoothing_width;
   assign s1_nf_in    = req_payload.sample_not_finite;
   assign s1_shape_in = (req_payload.shape_value < SHAPE_TWO) ? SHAPE_BELOW :
                        (req_payload.shape_value > SHAPE_TWO) ? SHAPE_ABOVE : SHAPE_EQUAL;

   assign s2_valid_in = s1_valid_ff;
   assign s2_f1_in    = F_W'(s1_prod1_ff >>> FRAC_BITS) + F_W'(s1_b1_ff);
   assign s2_f2_in    = F_W'(s1_prod2_ff >>> FRAC_BITS) + F_W'(s1_b2_ff);
   assign s2_h_in     = s1_h_ff;
   assign s2_h7_in    = H7_W'({s1_h_ff, 3'b000}) - H7_W'(s1_h_ff);
   assign s2_nf_in    = s1_nf_ff;
   assign s2_shape_in = s1_shape_ff;

   assign s3_valid_in = s2_valid_ff;
   assign s3_f1_in    = s2_f1_ff;
   assign s3_f2_in    = s2_f2_ff;
   assign s3_d_in     = D_W'(s2_f2_ff) - D_W'(s2_f1_ff);
   assign s3_h_in     = s2_h_ff;
   assign s3_h7_in    = s2_h7_ff;
   assign s3_nf_in    = s2_nf_ff;
   assign s3_shape_in = s2_shape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod1_ff <= s1_prod1_in;
         s1_prod2_ff <= s1_prod2_in;
         s1_b1_ff    <= s1_b1_in;
         s1_b2_ff    <= s1_b2_in;
         s1_h_ff     <= s1_h_in;
         s1_nf_ff    <= s1_nf_in;
         s1_shape_ff <= s1_shape_in;
         s2_f1_ff    <= s2_f1_in;
         s2_f2_ff    <= s2_f2_in;
         s2_h_ff     <= s2_h_in;
         s2_h7_ff    <= s2_h7_in;
         s2_nf_ff    <= s2_nf_in;
         s2_shape_ff <= s2_shape_in;
         s3_f1_ff    <= s3_f1_in;
         s3_f2_ff    <= s3_f2_in;
         s3_d_ff     <= s3_d_in;
         s3_h_ff     <= s3_h_in;
         s3_h7_ff    <= s3_h7_in;
         s3_nf_ff    <= s3_nf_in;
         s3_shape_ff <= s3_shape_in;
      end
   end

   // A zero width puts every difference at one of the two bounds.
   assign h7_s  = D_W'($signed({1'b0, s3_h7_ff}));
   assign upper = s3_d_ff >= h7_s;
   assign lower = s3_d_ff <= -h7_s;
   assign kind  = upper ? KIND_UPPER : (lower ? KIND_LOWER : KIND_INTERP);
   assign d_abs = s3_d_ff[D_W-1] ? -s3_d_ff : s3_d_ff;

   always_comb begin
      push_item.nf    = s3_nf_ff;
      push_item.shape = s3_shape_ff;
      push_item.kind  = kind;
      push_item.neg   = s3_d_ff[D_W-1];
      push_item.f1    = s3_f1_ff;
      push_item.f2    = s3_f2_ff;
      push_item.d     = s3_d_ff;
      push_item.h     = s3_h_ff;
      push_item.dmag  = (kind == KIND_INTERP) ? d_abs[DMAG_W-1:0] : '0;
   end

   assign push_valid = s3_valid_ff;

endmodule

// ----- sv/sbtl_queue.sv -----
// ----------------------------------------------------------------------------
// Softplus blend queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "softplus_blend_two_lines_defines.svh"

module sbtl_queue import sbtl_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  queue_item_type push_item,
   output logic           push_ready,
   output logic           pop_valid,
   output queue_item_type pop_item,
   input  logic           pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_item_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `SBTL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SBTL_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1))
   `SBTL_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - CNT_W'(1))

endmodule

// ----- sv/sbtl_back.sv -----
// ----------------------------------------------------------------------------
// Softplus blend back end
// Divides by the width, interpolates the softplus, blends and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "softplus_blend_two_lines_defines.svh"

module sbtl_back import sbtl_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   input  queue_item_type  pop_item,
   output logic            pop_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  logic            rsp_ready
);

   localparam int M_W = TAB_W + FRAC_BITS + 1;
   localparam logic [M_W-1:0]  M_HALF  = M_W'(1) << (FRAC_BITS - 1);
   localparam logic [HP_W:0]   HP_HALF = (HP_W + 1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [T_W-1:0] T_LIMIT = T_W'(64'sd7 <<< FRAC_BITS);

   logic adv;

   logic [Q_W:0]   div_valid_ff, div_valid_in;
   queue_item_type div_item_ff [Q_W+1];
   queue_item_type div_item_in [Q_W+1];
   logic [N_W-1:0] div_rem_ff [Q_W+1];
   logic [N_W-1:0] div_rem_in [Q_W+1];
   logic [Q_W-1:0] div_q_ff [Q_W+1];
   logic [Q_W-1:0] div_q_in [Q_W+1];

   logic                  t_valid_ff;
   queue_item_type        t_item_ff;
   logic signed [T_W-1:0] t_val_ff, t_val_in;
   logic signed [T_W-1:0] t_mag;

   logic                  i_valid_ff;
   queue_item_type        i_item_ff;
   logic [IDX_W-1:0]      i_idx_ff, i_idx_in;
   logic [FRAC_BITS-1:0]  i_frac_ff, i_frac_in;
   logic [IDX_W-1:0]      idx_raw;

   logic                  m_valid_ff;
   queue_item_type        m_item_ff;
   logic [M_W-1:0]        m_lo_ff, m_lo_in;
   logic [M_W-1:0]        m_hi_ff, m_hi_in;
   logic [FRAC_BITS:0]    one_minus;

   logic                  s_valid_ff;
   queue_item_type        s_item_ff;
   logic [SP_W-1:0]       s_sp_ff, s_sp_in;

   logic                  h_valid_ff;
   queue_item_type        h_item_ff;
   logic [HP_W-1:0]       h_hp_ff, h_hp_in;

   logic                  r_valid_ff;
   queue_item_type        r_item_ff;
   logic signed [R_W-1:0] r_val_ff, r_val_in;
   logic [HP_W:0]         hp_rnd;
   logic signed [D_W-1:0] p_val;

   logic                        out_valid_ff;
   logic signed [WORD_BITS-1:0] out_value_ff, out_value_in;
   logic                        out_mi_ff, out_mi_in;
   logic                        out_sat_ff, out_sat_in;
   logic                        ovf;

   logic                        t_interp;
   logic                        t_in_range;
   logic                        mi_clean;
   logic                        rsp_stalled;

   assign adv       = !out_valid_ff || rsp_ready;
   assign pop_ready = adv;

   assign div_valid_in   = {div_valid_ff[Q_W-1:0], pop_valid};
   assign div_item_in[0] = pop_item;
   assign div_rem_in[0]  = {pop_item.dmag, {FRAC_BITS{1'b0}}};
   assign div_q_in[0]    = '0;

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar j = 1; j <= Q_W; j++) begin : g_div
      localparam int K = Q_W - j;
      logic [N_W:0] trial;

      assign trial = {1'b0, div_rem_ff[j-1]}
                   - {1'b0, N_W'(div_item_ff[j-1].h) << K};
      assign div_rem_in[j]  = trial[N_W] ? div_rem_ff[j-1] : trial[N_W-1:0];
      assign div_q_in[j]    = div_q_ff[j-1] | (Q_W'(!trial[N_W]) << K);
      assign div_item_in[j] = div_item_ff[j-1];
   end

   assign t_mag    = T_W'({1'b0, div_q_ff[Q_W]})
                   + T_W'(div_item_ff[Q_W].neg && (div_rem_ff[Q_W] != '0));
   assign t_val_in = div_item_ff[Q_W].neg ? -t_mag : t_mag;

   assign idx_raw   = IDX_W'(t_val_ff >>> FRAC_BITS) + IDX_W'(IDX_OFFSET);
   assign i_idx_in  = (idx_raw > IDX_W'(TABLE_LEN - 2)) ? IDX_W'(TABLE_LEN - 2) : idx_raw;
   assign i_frac_in = t_val_ff[FRAC_BITS-1:0];

   assign one_minus = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, i_frac_ff};
   assign m_lo_in   = M_W'(SP_TABLE[i_idx_ff]) * M_W'(one_minus);
   assign m_hi_in   = M_W'(SP_TABLE[IDX_W'(i_idx_ff + 1'b1)]) * M_W'(i_frac_ff);

   assign s_sp_in = SP_W'((m_lo_ff + m_hi_ff + M_HALF) >> FRAC_BITS);

   assign h_hp_in = HP_W'(s_item_ff.h) * HP_W'(s_sp_ff);

   assign hp_rnd = (HP_W + 1)'(h_hp_ff) + HP_HALF;

   always_comb begin
      unique case (h_item_ff.kind)
         KIND_UPPER:  p_val = h_item_ff.d;
         KIND_LOWER:  p_val = '0;
         KIND_INTERP: p_val = D_W'(hp_rnd[HP_W:FRAC_BITS]);
         default:     p_val = '0;
      endcase
      unique case (h_item_ff.shape)
         SHAPE_BELOW: r_val_in = R_W'($signed(h_item_ff.f2)) - R_W'(p_val);
         SHAPE_ABOVE: r_val_in = R_W'($signed(h_item_ff.f1)) + R_W'(p_val);
         SHAPE_EQUAL: r_val_in = R_W'($signed(h_item_ff.f1));
         default:     r_val_in = R_W'($signed(h_item_ff.f1));
      endcase
   end

   assign ovf = r_val_ff[R_W-1:WORD_BITS-1] != {(R_W - WORD_BITS + 1){r_val_ff[R_W-1]}};

   always_comb begin
      if (r_item_ff.nf) begin
         out_value_in = '0;
         out_mi_in    = 1'b1;
         out_sat_in   = 1'b0;
      end else if (ovf) begin
         out_value_in = r_val_ff[R_W-1] ? {1'b1, {(WORD_BITS - 1){1'b0}}}
                                        : {1'b0, {(WORD_BITS - 1){1'b1}}};
         out_mi_in    = 1'b0;
         out_sat_in   = 1'b1;
      end else begin
         out_value_in = r_val_ff[WORD_BITS-1:0];
         out_mi_in    = 1'b0;
         out_sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
         t_valid_ff   <= 1'b0;
         i_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         s_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         div_valid_ff <= div_valid_in;
         t_valid_ff   <= div_valid_ff[Q_W];
         i_valid_ff   <= t_valid_ff;
         m_valid_ff   <= i_valid_ff;
         s_valid_ff   <= m_valid_ff;
         h_valid_ff   <= s_valid_ff;
         r_valid_ff   <= h_valid_ff;
         out_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_item_ff  <= div_item_in;
         div_rem_ff   <= div_rem_in;
         div_q_ff     <= div_q_in;
         t_item_ff    <= div_item_ff[Q_W];
         t_val_ff     <= t_val_in;
         i_item_ff    <= t_item_ff;
         i_idx_ff     <= i_idx_in;
         i_frac_ff    <= i_frac_in;
         m_item_ff    <= i_item_ff;
         m_lo_ff      <= m_lo_in;
         m_hi_ff      <= m_hi_in;
         s_item_ff    <= m_item_ff;
         s_sp_ff      <= s_sp_in;
         h_item_ff    <= s_item_ff;
         h_hp_ff      <= h_hp_in;
         r_item_ff    <= h_item_ff;
         r_val_ff     <= r_val_in;
         out_value_ff <= out_value_in;
         out_mi_ff    <= out_mi_in;
         out_sat_ff   <= out_sat_in;
      end
   end

   assign rsp_valid                  = out_valid_ff;
   assign rsp_payload.result_value   = out_value_ff;
   assign rsp_payload.minus_infinity = out_mi_ff;
   assign rsp_payload.saturated      = out_sat_ff;

   assign t_interp    = t_valid_ff && t_item_ff.kind == KIND_INTERP;
   assign t_in_range  = t_val_ff >= -T_LIMIT && t_val_ff < T_LIMIT;
   assign mi_clean    = out_value_ff == '0 && !out_sat_ff;
   assign rsp_stalled = out_valid_ff && !rsp_ready;

   `SBTL_ASSERT_NOW(a_ratio_range, clock, reset, t_interp, t_in_range)
   `SBTL_ASSERT_NOW(a_not_finite_clean, clock, reset, out_valid_ff && out_mi_ff, mi_clean)
   `SBTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, rsp_valid && $stable(rsp_payload))

endmodule

// ----- sv/softplus_blend_two_lines.sv -----
// ----------------------------------------------------------------------------
// Softplus blend of two lines
// Blends two lines of a sample through a width-scaled softplus of their gap.
// ----------------------------------------------------------------------------
// Requests arrive on req_if and carry a sample, its not-finite flag, the
// shape value and the coefficients of both lines with the smoothing width.
// Each request gives exactly one response on rsp_if, in request order.
// Most of the pipeline is the divider, which settles one quotient bit per
// pipeline stage.
// One request can be accepted in every cycle, so the sustained rate is one
// request per cycle while the receiver keeps taking responses.
// Reset clears every valid flag and the queue and holds req_if.ready low; no
// response is pending after it and the block accepts requests in the next
// cycle.
// When the receiver stalls, the output register holds its response and the
// back end halts; the front end keeps accepting until the queue holds
// QUEUE_DEPTH requests and its own last stage holds one more, then
// req_if.ready falls. The front-end stages move together, so a gap between
// them is not closed up while they wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module softplus_blend_two_lines import sbtl_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   sbtl_chan_if.sink   req_if,
   sbtl_chan_if.source rsp_if
);

   req_payload_type req_data;
   rsp_payload_type rsp_data;
   logic            push_valid;
   logic            push_ready;
   queue_item_type  push_item;
   logic            pop_valid;
   logic            pop_ready;
   queue_item_type  pop_item;
   logic            rsp_valid;
   logic            req_ready;

   assign req_data       = req_if.payload;
   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.payload = rsp_data;

   sbtl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_payload (req_data),
      .req_ready   (req_ready),
      .push_valid  (push_valid),
      .push_item   (push_item),
      .push_ready  (push_ready)
   );

   sbtl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   sbtl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_item    (pop_item),
      .pop_ready   (pop_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_data),
      .rsp_ready   (rsp_if.ready)
   );

endmodule
